// ===== rtl/dfp_pkg.sv =====
// Shared types, constants and codes of the dust frame parser.
package dfp_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int SLOT_W        = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W        = 7;
    localparam int LVL_W         = 16;
    localparam int SUM_W         = 22;
    localparam int AVG_W         = 20;
    localparam int FRAC_W        = 4;
    localparam int DVD_W         = SUM_W + FRAC_W;
    localparam int DIV_CNT_W     = $clog2(DVD_W);
    localparam int NUM_CH        = 3;
    localparam int CH_W          = 2;
    localparam int WIN_LEN       = 11;
    localparam int SUM_LEN       = 10;
    localparam int IDX_W         = 4;
    localparam int CFG_IDX_W     = 8;

    localparam logic [7:0] HDR0 = 8'hFE;
    localparam logic [7:0] HDR1 = 8'hA5;

    localparam logic [LVL_W-1:0] MIN_LEVEL_RST = 16'd0;
    localparam logic [LVL_W-1:0] MAX_LEVEL_RST = 16'd2500;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 8'd1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_CKSUM = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_SUM,
        ST_CHECK,
        ST_PUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef logic [NUM_CH-1:0][LVL_W-1:0] lvl_vec_t;

    typedef struct packed {
        logic            push;
        logic [CH_W-1:0] rd_ch;
    } hist_ctl_t;

endpackage

// ===== rtl/dfp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module dfp_div
    import dfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [FILL_W-1:0] divisor,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [FILL_W:0]      rem_reg, rem_next;
    logic [FILL_W-1:0]    dsr_reg, dsr_next;
    logic [FILL_W:0]      rem_sh;
    logic                 fits;

    assign rem_sh = {rem_reg[FILL_W-1:0], dvd_reg[DVD_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DVD_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ===== rtl/dfp_hist.sv =====
// Per-channel sample history, running sums, write slot and fill count.
module dfp_hist
    import dfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  hist_ctl_t         ctl,
    input  lvl_vec_t          sample,
    output logic [SUM_W-1:0]  rd_sum,
    output logic [FILL_W-1:0] fill
);

    logic [LVL_W-1:0]  hist_reg [NUM_CH][HISTORY_DEPTH];
    logic [SUM_W-1:0]  sum_reg  [NUM_CH];
    logic [SUM_W-1:0]  sum_next [NUM_CH];
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              full;

    assign full = fill_reg >= FILL_W'(HISTORY_DEPTH);

    always_comb begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        for (int c = 0; c < NUM_CH; c++) begin
            sum_next[c] = sum_reg[c];
        end
        if (ctl.push) begin
            for (int c = 0; c < NUM_CH; c++) begin
                sum_next[c] = sum_reg[c]
                            - (full ? SUM_W'(hist_reg[c][slot_reg]) : '0)
                            + SUM_W'(sample[c]);
            end
            slot_next = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
            if (!full) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
            fill_reg <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= '0;
            end
        end else begin
            slot_reg <= slot_next;
            fill_reg <= fill_next;
            for (int c = 0; c < NUM_CH; c++) begin
                sum_reg[c] <= sum_next[c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.push) begin
            for (int c = 0; c < NUM_CH; c++) begin
                hist_reg[c][slot_reg] <= sample[c];
            end
        end
    end

    always_comb begin
        case (ctl.rd_ch)
            2'd0:    rd_sum = sum_reg[0];
            2'd1:    rd_sum = sum_reg[1];
            2'd2:    rd_sum = sum_reg[2];
            default: rd_sum = '0;
        endcase
    end

    assign fill = fill_reg;

endmodule

// ===== rtl/dust_frame_parser_rolling_average.sv =====
// A byte that does not complete a header frees the input after the ST_HDR check.
// A bad-checksum or out-of-range frame gives its result after 10 checksum steps and the check; a good
// one goes on to three divisions (26 quotient bits, start, done), one per channel, on
// the shared divider, with s_tready low throughout. A waiting result stalls the input only
// when the next result is ready. Reset (aresetn low, synchronous) clears the window, sums,
// slot, fill count and limits (min 0, max 2500); history entries stay unset until written.
module dust_frame_parser_rolling_average
    import dfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] rx_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,    // [19:0] avg_fine, [39:20] avg_mid,
                                             // [59:40] avg_coarse, [66:60] samples_used
    output logic [1:0]           m_tuser,    // [1:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LVL_W-1:0]     cfg_data
);

    state_t            state_reg, state_next;
    logic [7:0]        win_reg  [WIN_LEN];
    logic [7:0]        win_next [WIN_LEN];
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        acc_reg, acc_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    status_t           status_reg, status_next;
    lvl_vec_t          val_reg, val_next;
    logic [AVG_W-1:0]  avg_reg  [NUM_CH];
    logic [AVG_W-1:0]  avg_next [NUM_CH];
    logic [LVL_W-1:0]  min_reg, max_reg;

    logic              m_valid_reg, m_valid_next;
    logic [71:0]       m_data_reg, m_data_next;
    logic [1:0]        m_user_reg, m_user_next;

    hist_ctl_t         hctl;
    logic [SUM_W-1:0]  rd_sum;
    logic [FILL_W-1:0] fill;
    logic              div_start, div_done;
    logic [DVD_W-1:0]  quotient;
    lvl_vec_t          frame_val;
    logic              in_rng;
    logic              s_beat;

    assign s_beat    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            frame_val[c] = {win_reg[4 + 2 * c], win_reg[5 + 2 * c]};
        end
        in_rng = 1'b1;
        for (int c = 0; c < NUM_CH; c++) begin
            if (frame_val[c] < min_reg || frame_val[c] > max_reg) begin
                in_rng = 1'b0;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        ch_next      = ch_reg;
        status_next  = status_reg;
        val_next     = val_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        hctl.push    = 1'b0;
        hctl.rd_ch   = ch_reg;
        div_start    = 1'b0;
        for (int i = 0; i < WIN_LEN; i++) begin
            win_next[i] = win_reg[i];
        end
        for (int c = 0; c < NUM_CH; c++) begin
            avg_next[c] = avg_reg[c];
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[WIN_LEN - 1] = s_tdata;
                    state_next = ST_HDR;
                end
            end
            ST_HDR: begin
                if (win_reg[0] == HDR0 && win_reg[1] == HDR1) begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                acc_next = acc_reg + win_reg[idx_reg];
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(SUM_LEN - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                for (int i = 0; i < WIN_LEN; i++) begin
                    win_next[i] = '0;
                end
                val_next = frame_val;
                for (int c = 0; c < NUM_CH; c++) begin
                    avg_next[c] = '0;
                end
                if (acc_reg != win_reg[WIN_LEN - 1]) begin
                    status_next = STATUS_CKSUM;
                    state_next  = ST_OUT;
                end else if (!in_rng) begin
                    status_next = STATUS_RANGE;
                    state_next  = ST_OUT;
                end else begin
                    status_next = STATUS_OK;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                hctl.push  = 1'b1;
                ch_next    = '0;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    avg_next[ch_reg] = quotient[AVG_W-1:0];
                    ch_next = ch_reg + 1'b1;
                    if (ch_reg == CH_W'(NUM_CH - 1)) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = status_reg;
                    m_data_next  = {5'd0,
                                    (status_reg == STATUS_OK) ? fill : FILL_W'(0),
                                    avg_reg[2], avg_reg[1], avg_reg[0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            min_reg     <= MIN_LEVEL_RST;
            max_reg     <= MAX_LEVEL_RST;
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= win_next[i];
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_LEVEL: min_reg <= cfg_data;
                    REG_MAX_LEVEL: max_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        idx_reg    <= idx_next;
        acc_reg    <= acc_next;
        ch_reg     <= ch_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        for (int c = 0; c < NUM_CH; c++) begin
            avg_reg[c] <= avg_next[c];
        end
    end

    dfp_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hctl),
        .sample  (val_reg),
        .rd_sum  (rd_sum),
        .fill    (fill)
    );

    dfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({rd_sum, FRAC_W'(0)}),
        .divisor  (fill),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== bench/dfp_frame_checker.sv =====
// Checker for the dust frame parser: tracks beats, predicts results and compares them.
`timescale 1ns / 1ps
module dfp_frame_checker
    import dfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [71:0]          m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LVL_W-1:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        status_t            status;
        logic [AVG_W-1:0]   fine;
        logic [AVG_W-1:0]   mid;
        logic [AVG_W-1:0]   coarse;
        logic [FILL_W-1:0]  used;
    } frame_result_t;

    logic [7:0]       win [WIN_LEN];
    logic [LVL_W-1:0] history [NUM_CH][HISTORY_DEPTH];
    logic [SUM_W-1:0] level_sums [NUM_CH];
    int unsigned      write_slot;
    int unsigned      fill_count;
    logic [LVL_W-1:0] min_level;
    logic [LVL_W-1:0] max_level;
    frame_result_t    expected_frames [$];

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    function automatic logic [AVG_W-1:0] q4_mean(input int ch);
        logic [31:0] scaled;
        scaled = 32'(level_sums[ch]) << FRAC_W;
        return AVG_W'(scaled / fill_count);
    endfunction

    task automatic note_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
        errors++;
        if (errors <= REPORT_MAX)
            $display("mismatch %s: expected %0d, got %0d", what, want_v, got_v);
    endtask

    task automatic shift_in_byte(input logic [7:0] rx);
        logic [7:0]       cks;
        logic [LVL_W-1:0] lvl [NUM_CH];
        frame_result_t    res;
        bit               bad_level;
        bit               full;
        for (int i = 0; i < WIN_LEN - 1; i++)
            win[i] = win[i + 1];
        win[WIN_LEN - 1] = rx;
        if (win[0] != HDR0 || win[1] != HDR1)
            return;
        cks = '0;
        for (int i = 0; i < SUM_LEN; i++)
            cks += win[i];
        bad_level = 1'b0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lvl[ch] = {win[4 + 2 * ch], win[5 + 2 * ch]};
            if (lvl[ch] < min_level || lvl[ch] > max_level)
                bad_level = 1'b1;
        end
        res = '0;
        if (cks != win[SUM_LEN]) begin
            res.status = STATUS_CKSUM;
        end else if (bad_level) begin
            res.status = STATUS_RANGE;
        end else begin
            full = fill_count >= HISTORY_DEPTH;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (full)
                    level_sums[ch] -= history[ch][write_slot];
                history[ch][write_slot] = lvl[ch];
                level_sums[ch] += lvl[ch];
            end
            write_slot = (write_slot + 1) % HISTORY_DEPTH;
            if (!full)
                fill_count++;
            res.status = STATUS_OK;
            res.fine   = q4_mean(0);
            res.mid    = q4_mean(1);
            res.coarse = q4_mean(2);
            res.used   = FILL_W'(fill_count);
        end
        for (int i = 0; i < WIN_LEN; i++)
            win[i] = '0;
        expected_frames.push_back(res);
    endtask

    always @(posedge aclk) begin : monitor
        frame_result_t got;
        frame_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < WIN_LEN; i++)
                win[i] = '0;
            for (int ch = 0; ch < NUM_CH; ch++)
                level_sums[ch] = '0;
            write_slot = 0;
            fill_count = 0;
            min_level  = MIN_LEVEL_RST;
            max_level  = MAX_LEVEL_RST;
            expected_frames.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MIN_LEVEL)
                    min_level = cfg_data;
                else if (cfg_index == REG_MAX_LEVEL)
                    max_level = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.fine   = m_tdata[19:0];
                got.mid    = m_tdata[39:20];
                got.coarse = m_tdata[59:40];
                got.used   = m_tdata[66:60];
                if (expected_frames.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("result beat with none expected: status %0d", m_tuser);
                end else begin
                    want = expected_frames.pop_front();
                    if (want.status !== got.status)
                        note_mismatch("status", want.status, got.status);
                    if (want.fine !== got.fine)
                        note_mismatch("avg_fine", want.fine, got.fine);
                    if (want.mid !== got.mid)
                        note_mismatch("avg_mid", want.mid, got.mid);
                    if (want.coarse !== got.coarse)
                        note_mismatch("avg_coarse", want.coarse, got.coarse);
                    if (want.used !== got.used)
                        note_mismatch("samples_used", want.used, got.used);
                end
            end
            if (s_tvalid && s_tready)
                shift_in_byte(s_tdata);
        end
        outstanding <= expected_frames.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the dust frame parser: clock, reset, byte and register traffic, verdict.
`timescale 1ns / 1ps
module tb
    import dfp_pkg::*;
();

    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 8'd2;

    typedef logic [WIN_LEN-1:0][7:0] frame_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [71:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LVL_W-1:0]     cfg_data;

    int               errors;
    int               outstanding;
    int               sent_bytes;
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_reqs;
    int               quiet_cycles;
    logic [LVL_W-1:0] lim_lo;
    logic [LVL_W-1:0] lim_hi;

    dust_frame_parser_rolling_average i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dfp_frame_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : receiver
        int hold_seen;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic frame_t make_frame(input logic [LVL_W-1:0] a, b, c, input bit bad_sum);
        frame_t     f;
        logic [7:0] sum;
        f[0]  = HDR0;
        f[1]  = HDR1;
        f[2]  = 8'($urandom);
        f[3]  = 8'($urandom);
        f[4]  = a[15:8];
        f[5]  = a[7:0];
        f[6]  = b[15:8];
        f[7]  = b[7:0];
        f[8]  = c[15:8];
        f[9]  = c[7:0];
        sum = '0;
        for (int i = 0; i < SUM_LEN; i++)
            sum += f[i];
        f[SUM_LEN] = bad_sum ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        return f;
    endfunction

    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return lim_lo;
            3: return lim_hi;
            4: return lim_lo - 1'b1;
            5: return lim_hi + 1'b1;
            default: return LVL_W'($urandom_range(lim_hi, lim_lo));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (sent_bytes < 470) begin
            send_idle_pct = 33;
            recv_idle_pct = 51;
        end else if (sent_bytes < 940) begin
            send_idle_pct = 51;
            recv_idle_pct = 33;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sent_bytes++;
    endtask

    task automatic send_frame(input frame_t f, input int keep);
        for (int i = 0; i < keep; i++)
            send_byte(f[i]);
    endtask

    task automatic send_traffic(input int n_bytes);
        int stop_at;
        int pick;
        stop_at = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(make_frame(pick_level(), pick_level(), pick_level(),
                                      $urandom_range(9) == 0), WIN_LEN);
            end else if (pick < 85) begin
                send_frame(make_frame(pick_level(), pick_level(), pick_level(), 1'b0),
                           $urandom_range(WIN_LEN - 1, 1));
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    case ($urandom_range(3))
                        0: send_byte(HDR0);
                        1: send_byte(HDR1);
                        default: send_byte(8'($urandom));
                    endcase
                end
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic run_phase(input logic [LVL_W-1:0] lo, hi, input int n_bytes,
                             input bit with_hold);
        wait_drained();
        write_reg(REG_MIN_LEVEL, lo);
        write_reg(CFG_IDX_W'($urandom_range(255, REG_FIRST_UNUSED)), LVL_W'($urandom));
        write_reg(REG_MAX_LEVEL, hi);
        cfg_valid <= 1'b0;
        lim_lo = lo;
        lim_hi = hi;
        if (with_hold)
            hold_reqs <= hold_reqs + 1;
        send_traffic(n_bytes);
    endtask

    initial begin : stimulus
        logic [LVL_W-1:0] rnd_lo;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sent_bytes    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs     = 0;
        quiet_cycles  = 0;
        lim_lo        = MIN_LEVEL_RST;
        lim_hi        = MAX_LEVEL_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        send_byte(HDR0);
        send_byte(8'h00);
        send_frame(make_frame(16'h0000, MAX_LEVEL_RST, 16'h00FF, 1'b0), WIN_LEN);
        send_frame(make_frame(16'hFFFF, 16'h0001, 16'h8000, 1'b1), WIN_LEN);
        send_traffic(150);

        run_phase(16'd0, 16'hFFFF, 210, 1'b0);
        run_phase(16'd1000, 16'd3000, 210, 1'b1);
        run_phase(16'd4000, 16'd1000, 210, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 210, 1'b0);
        run_phase(16'd0, 16'd0, 210, 1'b0);
        rnd_lo = LVL_W'($urandom_range(2000));
        run_phase(rnd_lo, rnd_lo + LVL_W'($urandom_range(20000)), 210, 1'b0);

        wait_drained();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
